>>> rtl/priority_lock_handoff_assert.svh
// Assertion macros shared by the lock handoff checkers.
`ifndef PRIORITY_LOCK_HANDOFF_ASSERT_SVH
`define PRIORITY_LOCK_HANDOFF_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define PLH_ASSERT_IMP(lbl, ck, rs, a, c) \
  lbl: assert property (@(posedge ck) disable iff (rs) (a) |-> (c)) \
    else $error("lock handoff check failed");

// Next-cycle implication, disabled during reset.
`define PLH_ASSERT_NXT(lbl, ck, rs, a, c) \
  lbl: assert property (@(posedge ck) disable iff (rs) (a) |=> (c)) \
    else $error("lock handoff check failed");

`endif

>>> rtl/plh_pkg.sv
// Shared constants, status codes and control types for the lock handoff block.
package plh_pkg;

  localparam int MAX_WAITERS_DEF = 64;
  localparam int PRIO_BITS_DEF   = 8;
  localparam int ID_BITS_DEF     = 6;

  localparam int ST_W = 3;

  localparam logic [ST_W-1:0] ST_GRANTED = 3'd0;
  localparam logic [ST_W-1:0] ST_QUEUED  = 3'd1;
  localparam logic [ST_W-1:0] ST_HANDOFF = 3'd2;
  localparam logic [ST_W-1:0] ST_FREED   = 3'd3;
  localparam logic [ST_W-1:0] ST_FULL    = 3'd4;

  localparam logic OP_ACQUIRE = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  typedef struct packed {
    logic en;
    logic first;
  } cmp_ctl_t;

endpackage

>>> rtl/plh_best.sv
// Shared priority comparator that tracks the best waiter seen during a scan.
module plh_best #(
  parameter int ID_BITS   = plh_pkg::ID_BITS_DEF,
  parameter int PRIO_BITS = plh_pkg::PRIO_BITS_DEF,
  parameter int POS_W     = 6
) (
  input  logic                 clk,
  input  plh_pkg::cmp_ctl_t    ctl,
  input  logic [ID_BITS-1:0]   id,
  input  logic [PRIO_BITS-1:0] prio,
  input  logic [POS_W-1:0]     pos,
  output logic [ID_BITS-1:0]   best_id,
  output logic [POS_W-1:0]     best_pos
);

  logic [PRIO_BITS-1:0] best_prio;

  // later position wins ties, so take equal priorities too
  always_ff @(posedge clk) begin
    if (ctl.en && (ctl.first || prio >= best_prio)) begin
      best_prio <= prio;
      best_id   <= id;
      best_pos  <= pos;
    end
  end

endmodule

>>> rtl/priority_lock_handoff.sv
// Top level of the priority lock handoff block: sequencer, waiter store and result beat.
//
// One lock with a queue of up to MAX_WAITERS waiters kept in arrival order in a
// single-port-read memory. An acquire registers its result, which then moves to
// the output register. A release with N waiters reads every entry once through
// the memory read port into one shared comparator, then closes the gap behind
// the chosen waiter by moving the K newer entries down one place, a step that is
// skipped when the newest waiter wins. A release of a lock with no waiters
// skips the scan. The next beat is accepted as soon as the sequencer is idle,
// even while the previous result still waits in the output register.
module priority_lock_handoff #(
  parameter int MAX_WAITERS = plh_pkg::MAX_WAITERS_DEF,
  parameter int PRIO_BITS   = plh_pkg::PRIO_BITS_DEF,
  parameter int ID_BITS     = plh_pkg::ID_BITS_DEF,
  localparam int IN_W       = ((ID_BITS + PRIO_BITS + 7) / 8) * 8,
  localparam int OUT_W      = ((plh_pkg::ST_W + ID_BITS + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,  // requester_id, priority_req, zero pad
  input  logic             s_tuser,  // opcode
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata,  // status, new_owner_id, zero pad
  output logic             m_tuser   // owner_valid
);

  localparam int ADDR_W  = $clog2(MAX_WAITERS);
  localparam int CNT_W   = ADDR_W + 1;
  localparam int ENTRY_W = ID_BITS + PRIO_BITS;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_FIND_END,
    S_SEL,
    S_SHIFT,
    S_SHIFT_END,
    S_SEND
  } state_t;

  state_t state;

  logic                  held;
  logic [CNT_W-1:0]      count;
  logic [ADDR_W-1:0]     idx;
  logic                  rd_pend;
  logic [ADDR_W-1:0]     rd_tag;
  logic [ENTRY_W-1:0]    rdata;
  logic [ENTRY_W-1:0]    mem [MAX_WAITERS];

  logic [plh_pkg::ST_W-1:0] res_status;
  logic [ID_BITS-1:0]       res_id;
  logic                     res_ok;
  logic [plh_pkg::ST_W-1:0] out_status;
  logic [ID_BITS-1:0]       out_id;
  logic                     out_ok;

  logic                  accept;
  logic                  op;
  logic [ID_BITS-1:0]    in_id;
  logic [PRIO_BITS-1:0]  in_prio;
  logic                  full;
  logic [ADDR_W-1:0]     cnt_last;
  logic                  we;
  logic [ADDR_W-1:0]     waddr;
  logic [ENTRY_W-1:0]    wdata;
  logic                  scanning;
  logic                  shifting;
  logic [CNT_W-1:0]      after_best;

  plh_pkg::cmp_ctl_t     cmp_ctl;
  logic [ID_BITS-1:0]    best_id;
  logic [ADDR_W-1:0]     best_pos;

  assign accept   = s_tvalid && s_tready;
  assign s_tready = (state == S_IDLE);
  assign op       = s_tuser;
  assign in_id    = s_tdata[ID_BITS-1:0];
  assign in_prio  = s_tdata[ID_BITS +: PRIO_BITS];
  assign full     = (count == CNT_W'(MAX_WAITERS));
  assign cnt_last = ADDR_W'(count - 1'b1);
  assign scanning = (state == S_SCAN) || (state == S_FIND_END);
  assign shifting = (state == S_SHIFT) || (state == S_SHIFT_END);
  assign after_best = CNT_W'(best_pos) + 1'b1;

  assign cmp_ctl.en    = rd_pend && scanning;
  assign cmp_ctl.first = (rd_tag == '0);

  plh_best #(
    .ID_BITS   (ID_BITS),
    .PRIO_BITS (PRIO_BITS),
    .POS_W     (ADDR_W)
  ) u_best (
    .clk      (clk),
    .ctl      (cmp_ctl),
    .id       (rdata[ID_BITS-1:0]),
    .prio     (rdata[ID_BITS +: PRIO_BITS]),
    .pos      (rd_tag),
    .best_id  (best_id),
    .best_pos (best_pos)
  );

  always_comb begin
    we    = 1'b0;
    waddr = count[ADDR_W-1:0];
    wdata = {in_prio, in_id};
    if (accept && op == plh_pkg::OP_ACQUIRE && held && !full) begin
      we = 1'b1;
    end else if (rd_pend && shifting) begin
      we    = 1'b1;
      waddr = ADDR_W'(rd_tag - 1'b1);
      wdata = rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      held     <= 1'b0;
      count    <= '0;
      rd_pend  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      rd_pend <= (state == S_SCAN) || (state == S_SHIFT);
      rd_tag  <= idx;
      if (m_tvalid && m_tready && state != S_SEND) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (op == plh_pkg::OP_ACQUIRE) begin
              state <= S_SEND;
              if (!held) begin
                held       <= 1'b1;
                res_status <= plh_pkg::ST_GRANTED;
                res_id     <= in_id;
                res_ok     <= 1'b1;
              end else if (full) begin
                res_status <= plh_pkg::ST_FULL;
                res_id     <= '0;
                res_ok     <= 1'b0;
              end else begin
                count      <= count + 1'b1;
                res_status <= plh_pkg::ST_QUEUED;
                res_id     <= '0;
                res_ok     <= 1'b0;
              end
            end else if (count == '0) begin
              held       <= 1'b0;
              res_status <= plh_pkg::ST_FREED;
              res_id     <= '0;
              res_ok     <= 1'b0;
              state      <= S_SEND;
            end else begin
              idx   <= '0;
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (idx == cnt_last) begin
            state <= S_FIND_END;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_FIND_END: begin
          state <= S_SEL;
        end
        S_SEL: begin
          res_status <= plh_pkg::ST_HANDOFF;
          res_id     <= best_id;
          res_ok     <= 1'b1;
          if (after_best == count) begin
            count <= count - 1'b1;
            state <= S_SEND;
          end else begin
            idx   <= ADDR_W'(after_best);
            state <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          if (idx == cnt_last) begin
            state <= S_SHIFT_END;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_SHIFT_END: begin
          count <= count - 1'b1;
          state <= S_SEND;
        end
        S_SEND: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid   <= 1'b1;
            out_status <= res_status;
            out_id     <= res_id;
            out_ok     <= res_ok;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign m_tdata = OUT_W'({out_id, out_status});
  assign m_tuser = out_ok;

endmodule

>>> rtl/plh_checker.sv
// Port-level checker for the lock handoff block and its bind.
`include "priority_lock_handoff_assert.svh"

module plh_checker #(
  parameter int ID_BITS = plh_pkg::ID_BITS_DEF,
  parameter int OUT_W   = 16
) (
  input logic             clk,
  input logic             rst,
  input logic             s_tvalid,
  input logic             s_tready,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata,
  input logic             m_tuser
);

  logic [plh_pkg::ST_W-1:0] st;
  logic [ID_BITS-1:0]       who;
  logic                     owner_code;

  assign st  = m_tdata[plh_pkg::ST_W-1:0];
  assign who = m_tdata[plh_pkg::ST_W +: ID_BITS];
  assign owner_code = (st == plh_pkg::ST_GRANTED) || (st == plh_pkg::ST_HANDOFF);

  `PLH_ASSERT_NXT(a_hold_beat, clk, rst, m_tvalid && !m_tready, $stable(m_tdata) && m_tvalid)
  `PLH_ASSERT_IMP(a_owner_flag, clk, rst, m_tvalid, m_tuser == owner_code)
  `PLH_ASSERT_IMP(a_no_owner_zero, clk, rst, m_tvalid && !m_tuser, who == '0)
  `PLH_ASSERT_NXT(a_one_at_a_time, clk, rst, s_tvalid && s_tready, !s_tready)

endmodule

bind priority_lock_handoff plh_checker #(
  .ID_BITS (ID_BITS),
  .OUT_W   (OUT_W)
) u_plh_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
